// ===== rtl/core/sparse_set_component_table_top_defines.svh =====
// assertion macros for the sparse set table
`ifndef SPARSE_SET_COMPONENT_TABLE_TOP_DEFINES_SVH
`define SPARSE_SET_COMPONENT_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sst_pkg.sv =====
package sst_pkg;

    localparam int ENTITY_SLOTS = 1024;
    localparam int DATA_W       = 32;
    localparam int ENTITY_W     = 10;
    localparam int REQ_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 10;
    localparam int SLOT_W       = $clog2(ENTITY_SLOTS);
    localparam int SPARSE_W     = SLOT_W + 1;
    localparam int DENSE_W      = SLOT_W + DATA_W;

    localparam logic [REQ_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] OP_ADD    = 2'd1;
    localparam logic [REQ_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } sparse_entry_t;

    typedef struct packed {
        logic [SLOT_W-1:0] ent;
        logic [DATA_W-1:0] data;
    } dense_entry_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        sparse_entry_t     wdata;
    } sparse_cmd_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        dense_entry_t      wdata;
    } dense_cmd_t;

    typedef struct packed {
        logic                   found;
        logic [DATA_W-1:0]      data;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] live_count;
    } result_t;

endpackage

// ===== rtl/core/sparse_set_component_table_top.sv =====
// result path: an absent id, an add of a new id or an unused code is answered in S_LOOK after
// the sparse read; a lookup or add of a present id also reads the dense table in S_DENSE, and a
// remove of a present id goes on to S_REM2; in_ready is high only in S_IDLE, so the sequencer
// takes no new item until it is through with the last; the output register lets the next item
// enter while a result waits to be taken. reset: asynchronous, clears control state, then a
// pass over all 1024 entries clears the sparse table with in_ready low
module sparse_set_component_table_top import sst_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [ENTITY_W-1:0]    entity,
    input  logic [DATA_W-1:0]      value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic [DATA_W-1:0]      data,
    output logic [STATUS_W-1:0]    status,
    output logic [COUNT_OUT_W-1:0] live_count
);

    logic          res_valid;
    logic          res_ready;
    result_t       res;
    sparse_cmd_t   sp_cmd;
    sparse_entry_t sp_rd;
    dense_cmd_t    dn_cmd;
    dense_entry_t  dn_rd;
    logic          out_valid_reg;
    result_t       out_reg;

    sst_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .entity    (entity),
        .value     (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .sp_cmd    (sp_cmd),
        .sp_rd     (sp_rd),
        .dn_cmd    (dn_cmd),
        .dn_rd     (dn_rd)
    );

    sst_ram #(
        .WIDTH (SPARSE_W),
        .DEPTH (ENTITY_SLOTS)
    ) u_sparse (
        .clk   (clk),
        .we    (sp_cmd.we),
        .addr  (sp_cmd.addr),
        .wdata (sp_cmd.wdata),
        .rdata (sp_rd)
    );

    sst_ram #(
        .WIDTH (DENSE_W),
        .DEPTH (ENTITY_SLOTS)
    ) u_dense (
        .clk   (clk),
        .we    (dn_cmd.we),
        .addr  (dn_cmd.addr),
        .wdata (dn_cmd.wdata),
        .rdata (dn_rd)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = out_reg.found;
    assign data       = out_reg.data;
    assign status     = out_reg.status;
    assign live_count = out_reg.live_count;

endmodule

// ===== rtl/core/sst_ram.sv =====
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sst_seq.sv =====
`include "sparse_set_component_table_top_defines.svh"

module sst_seq import sst_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [ENTITY_W-1:0] entity,
    input  logic [DATA_W-1:0]   value,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res,
    output sparse_cmd_t         sp_cmd,
    input  sparse_entry_t       sp_rd,
    output dense_cmd_t          dn_cmd,
    input  dense_entry_t        dn_rd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_DENSE = 3'd3;
    localparam logic [2:0] S_REM2  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [REQ_W-1:0]  op_reg, op_next;
    logic [SLOT_W-1:0] id_reg, id_next;
    logic              usable_reg, usable_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [SLOT_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // shared step unit: clear sweep, append and swap-remove all use it
    logic              alu_dec;
    logic [SLOT_W-1:0] alu_a, alu_step, alu_sum;
    logic              present_now;
    logic              res_fire;

    assign alu_a    = (state_reg == S_CLEAR) ? clr_reg : count_reg;
    assign alu_dec  = (state_reg != S_CLEAR) && (op_reg == OP_REMOVE);
    assign alu_step = alu_dec ? {SLOT_W{1'b1}} : SLOT_W'(1);
    assign alu_sum  = alu_a + alu_step;

    assign present_now = usable_reg && sp_rd.valid;
    assign in_ready    = (state_reg == S_IDLE);
    assign res_fire    = res_valid && res_ready;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        usable_next    = usable_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        slot_next      = slot_reg;
        sp_cmd.we      = 1'b0;
        sp_cmd.addr    = id_reg;
        sp_cmd.wdata   = '0;
        dn_cmd.we      = 1'b0;
        dn_cmd.addr    = slot_reg;
        dn_cmd.wdata   = '0;
        res_valid      = 1'b0;
        res.found      = 1'b0;
        res.data       = '0;
        res.status     = ST_OK;
        res.live_count = COUNT_OUT_W'(count_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                sp_cmd.we   = 1'b1;
                sp_cmd.addr = clr_reg;
                clr_next    = alu_sum;
                if (clr_reg == SLOT_W'(ENTITY_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                sp_cmd.addr = SLOT_W'(entity);
                if (in_valid)
                begin
                    op_next     = req_type;
                    id_next     = SLOT_W'(entity);
                    usable_next = (entity != '0) && (32'(entity) < 32'(ENTITY_SLOTS));
                    val_next    = value;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                slot_next = sp_rd.slot;
                unique case (op_reg)
                    OP_LOOKUP:
                    begin
                        if (present_now)
                        begin
                            dn_cmd.addr = sp_rd.slot;
                            state_next  = S_DENSE;
                        end
                        else
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_ABSENT;
                        end
                    end
                    OP_ADD:
                    begin
                        if (present_now)
                        begin
                            dn_cmd.addr = sp_rd.slot;
                            state_next  = S_DENSE;
                        end
                        else if (!usable_reg)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_REJECT;
                        end
                        else
                        begin
                            res_valid      = 1'b1;
                            res.data       = val_reg;
                            res.live_count = COUNT_OUT_W'(alu_sum);
                            // append at the end of the dense arrays
                            sp_cmd.addr    = id_reg;
                            sp_cmd.wdata   = '{valid: 1'b1, slot: count_reg};
                            dn_cmd.addr    = count_reg;
                            dn_cmd.wdata   = '{ent: id_reg, data: val_reg};
                            if (res_ready)
                            begin
                                sp_cmd.we  = 1'b1;
                                dn_cmd.we  = 1'b1;
                                count_next = alu_sum;
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (present_now)
                        begin
                            dn_cmd.addr = alu_sum;
                            state_next  = S_DENSE;
                        end
                        else
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_ABSENT;
                        end
                    end
                    default:
                    begin
                        res_valid = 1'b1;
                    end
                endcase
                if (res_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DENSE:
            begin
                if (op_reg == OP_REMOVE)
                begin
                    // move the last entry into the hole and relink it
                    dn_cmd.we    = 1'b1;
                    dn_cmd.addr  = slot_reg;
                    dn_cmd.wdata = dn_rd;
                    sp_cmd.we    = 1'b1;
                    sp_cmd.addr  = dn_rd.ent;
                    sp_cmd.wdata = '{valid: 1'b1, slot: slot_reg};
                    state_next   = S_REM2;
                end
                else
                begin
                    res_valid = 1'b1;
                    res.found = 1'b1;
                    res.data  = dn_rd.data;
                    if (res_ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REM2:
            begin
                sp_cmd.we      = 1'b1;
                sp_cmd.addr    = id_reg;
                sp_cmd.wdata   = '0;
                res_valid      = 1'b1;
                res.found      = 1'b1;
                res.live_count = COUNT_OUT_W'(alu_sum);
                if (res_ready)
                begin
                    count_next = alu_sum;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        usable_reg <= usable_next;
        val_reg    <= val_next;
        slot_reg   <= slot_next;
    end

    `SST_ASSERT_NXT(a_add_grows, (state_reg == S_LOOK) && res_fire && (op_reg == OP_ADD) && usable_reg && !sp_rd.valid, count_reg == $past(count_reg) + SLOT_W'(1), "append did not grow the count")
    `SST_ASSERT_NXT(a_rem_shrinks, (state_reg == S_REM2) && res_fire, count_reg == $past(count_reg) - SLOT_W'(1), "remove did not shrink the count")
    `SST_ASSERT_IMP(a_rem_nonempty, (state_reg == S_DENSE) && (op_reg == OP_REMOVE), count_reg != '0, "remove of a present id with an empty table")
    `SST_ASSERT_IMP(a_clear_quiet, state_reg == S_CLEAR, !res_valid && (count_reg == '0), "result or count change during clearing pass")

endmodule
